// ===== sv/abtc_pkg.sv =====
// Shared types, codes and constants for the auto bracket threshold controller.
// Depends on nothing; used by the top level and its port checker.
`default_nettype none

package abtc_pkg;

  // Request kinds carried on the input tuser.
  typedef enum logic [1:0] {
    OP_FRAME   = 2'd0,
    OP_COUNTS  = 2'd1,
    OP_RESTART = 2'd2
  } op_t;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_START_THRESHOLD = 2'd0,
    REG_START_OVER      = 2'd1,
    REG_START_UNDER     = 2'd2,
    REG_FRAME_INTERVAL  = 2'd3
  } reg_idx_t;

  // Field widths.
  localparam int ThrW   = 8;
  localparam int CountW = 7;
  localparam int FrameW = 16;
  localparam int CfgW   = 16;

  // Most markers a single trial can report; larger counts saturate here.
  localparam int MaxMarkers = 64;
  localparam int SatW       = 11;

  // Reset values.
  localparam logic [ThrW-1:0]   ResetThreshold = 8'd100;
  localparam logic [ThrW-1:0]   ResetBracket   = 8'd1;
  localparam logic [FrameW-1:0] ResetInterval  = 16'd0;
  localparam logic [ThrW-1:0]   ThrMax         = 8'd255;

  // Bit positions of the result fields in the output tdata.
  localparam int OutEvalBit   = 0;
  localparam int OutOverLsb   = 1;
  localparam int OutUnderLsb  = 9;
  localparam int OutUseLsb    = 17;
  localparam int OutReuseBit  = 25;
  localparam int OutRejectBit = 26;
  localparam int OutDataW     = 32;
  localparam int InDataW      = 24;

  // Clamp a reported marker count to the most a trial can find.
  function automatic logic [SatW-1:0] sat_count(input logic [CountW-1:0] c);
    logic [SatW-1:0] ext;
    ext = {{(SatW-CountW){1'b0}}, c};
    if (ext > SatW'(MaxMarkers)) begin
      return SatW'(MaxMarkers);
    end
    return ext;
  endfunction

endpackage

`default_nettype wire

// ===== sv/auto_bracket_threshold_controller_unit.sv =====
// A request is held in the input register while it is computed, and its result
// is then registered in the output register until it is taken.
// Throughput: one request per cycle; the compute stage stalls only while the
// output register holds a result that has not been taken.
// Reset (rst, synchronous, active high): threshold 100, brackets 1, countdown
// 0, no evaluation pending, configuration back to its reset values.
// Top level of the auto bracket threshold controller; uses abtc_pkg.
`default_nettype none

module auto_bracket_threshold_controller_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  // Configuration write port
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  // Request stream
  input  wire logic        s_axis_tvalid,
  output      logic        s_axis_tready,
  // tdata: count_over [6:0], count_under [13:7], count_center [20:14], zeros [23:21]
  input  wire logic [23:0] s_axis_tdata,
  // tuser: op [1:0]
  input  wire logic [1:0]  s_axis_tuser,
  // Result stream
  output      logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // tdata: evaluate [0], trial_over [8:1], trial_under [16:9],
  //        use_threshold [24:17], reuse_center [25], rejected [26], zeros [31:27]
  output      logic [31:0] m_axis_tdata
);

  localparam int ThrW   = abtc_pkg::ThrW;
  localparam int CountW = abtc_pkg::CountW;
  localparam int FrameW = abtc_pkg::FrameW;
  localparam int SatW   = abtc_pkg::SatW;

  // Configuration registers
  logic [ThrW-1:0]   start_threshold;
  logic [ThrW-1:0]   start_over;
  logic [ThrW-1:0]   start_under;
  logic [FrameW-1:0] frame_interval;

  // Controller state
  logic [ThrW-1:0]   threshold, threshold_next;
  logic [ThrW-1:0]   bracket_over, bracket_over_next;
  logic [ThrW-1:0]   bracket_under, bracket_under_next;
  logic [FrameW-1:0] frames_left, frames_left_next;
  logic              pending, pending_next;
  logic [ThrW-1:0]   held_over, held_over_next;
  logic [ThrW-1:0]   held_under, held_under_next;

  // Input register
  logic              in_valid;
  abtc_pkg::op_t     in_op;
  logic [CountW-1:0] in_c_over, in_c_under, in_c_center;

  // Result fields of the request in the compute stage
  logic              r_eval, r_reuse, r_reject;
  logic [ThrW-1:0]   r_over, r_under;

  logic advance;

  // Working values
  logic [SatW-1:0]   c_over, c_under, c_center;
  logic [ThrW:0]     up_sum, bo9, bu9;
  logic [ThrW+1:0]   ctr_plus;
  logic [ThrW-1:0]   chosen;
  logic signed [ThrW+1:0] diff, step_up, step_dn;

  // The compute stage moves on when the output register is free or being read.
  assign advance       = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = !in_valid || advance;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      start_threshold <= abtc_pkg::ResetThreshold;
      start_over      <= abtc_pkg::ResetBracket;
      start_under     <= abtc_pkg::ResetBracket;
      frame_interval  <= abtc_pkg::ResetInterval;
    end else if (cfg_we) begin
      unique case (abtc_pkg::reg_idx_t'(cfg_index))
        abtc_pkg::REG_START_THRESHOLD: start_threshold <= cfg_data[ThrW-1:0];
        abtc_pkg::REG_START_OVER:      start_over      <= cfg_data[ThrW-1:0];
        abtc_pkg::REG_START_UNDER:     start_under     <= cfg_data[ThrW-1:0];
        abtc_pkg::REG_FRAME_INTERVAL:  frame_interval  <= cfg_data[FrameW-1:0];
        default: ;
      endcase
    end
  end

  // Input register: takes a new request whenever it is empty or the compute stage moves on.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_op       <= abtc_pkg::op_t'(s_axis_tuser);
      in_c_over   <= s_axis_tdata[CountW-1:0];
      in_c_under  <= s_axis_tdata[2*CountW-1:CountW];
      in_c_center <= s_axis_tdata[3*CountW-1:2*CountW];
    end
  end

  // Per-request decision and next state.
  always_comb begin
    threshold_next     = threshold;
    bracket_over_next  = bracket_over;
    bracket_under_next = bracket_under;
    frames_left_next   = frames_left;
    pending_next       = pending;
    held_over_next     = held_over;
    held_under_next    = held_under;
    r_eval   = 1'b0;
    r_reuse  = 1'b0;
    r_reject = 1'b0;
    r_over   = '0;
    r_under  = '0;

    c_over   = abtc_pkg::sat_count(in_c_over);
    c_under  = abtc_pkg::sat_count(in_c_under);
    c_center = abtc_pkg::sat_count(in_c_center);

    // Trial thresholds, clamped to the pixel range.
    up_sum = {1'b0, threshold} + {1'b0, bracket_over};

    // Widened brackets when the centre wins.
    bo9 = {1'b0, bracket_over};
    bu9 = {1'b0, bracket_under};
    if (bracket_over < bracket_under) begin
      bo9 = bo9 + 1'b1;
    end else if (bracket_over > bracket_under) begin
      bu9 = bu9 + 1'b1;
    end else begin
      bo9 = bo9 + 1'b1;
      bu9 = bu9 + 1'b1;
    end
    ctr_plus = {2'b0, threshold} + {1'b0, bo9};

    // Step towards the better side and half-step brackets.
    chosen  = (c_over >= c_under) ? held_over : held_under;
    diff    = $signed({2'b0, chosen}) - $signed({2'b0, threshold});
    step_up = (diff + 10'sd1) >>> 1;
    step_dn = (10'sd1 - diff) >>> 1;

    if (in_valid) begin
      unique case (in_op)
        abtc_pkg::OP_FRAME: begin
          if (frames_left != '0) begin
            frames_left_next = frames_left - 1'b1;
          end else begin
            held_over_next  = up_sum[ThrW] ? abtc_pkg::ThrMax : up_sum[ThrW-1:0];
            held_under_next = (bracket_under > threshold) ? '0
                                                          : threshold - bracket_under;
            pending_next    = 1'b1;
            r_eval  = 1'b1;
            r_over  = held_over_next;
            r_under = held_under_next;
          end
        end
        abtc_pkg::OP_COUNTS: begin
          if (!pending) begin
            r_reject = 1'b1;
          end else begin
            r_over  = held_over;
            r_under = held_under;
            if (c_over <= c_center && c_under <= c_center) begin
              bracket_over_next  = (ctr_plus >= {2'b0, abtc_pkg::ThrMax})
                                   ? abtc_pkg::ResetBracket : bo9[ThrW-1:0];
              bracket_under_next = (bu9 >= {1'b0, threshold})
                                   ? abtc_pkg::ResetBracket : bu9[ThrW-1:0];
              r_reuse = 1'b1;
            end else begin
              threshold_next = chosen;
              if (diff > 10'sd0) begin
                bracket_over_next  = step_up[ThrW-1:0];
                bracket_under_next = abtc_pkg::ResetBracket;
              end else begin
                bracket_over_next  = abtc_pkg::ResetBracket;
                bracket_under_next = step_dn[ThrW-1:0];
              end
            end
            frames_left_next = frame_interval;
            pending_next     = 1'b0;
          end
        end
        abtc_pkg::OP_RESTART: begin
          threshold_next     = start_threshold;
          bracket_over_next  = start_over;
          bracket_under_next = start_under;
          frames_left_next   = '0;
          pending_next       = 1'b0;
        end
        default: ;
      endcase
    end
  end

  // State update, one request per cycle in the compute stage while it moves on.
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold     <= abtc_pkg::ResetThreshold;
      bracket_over  <= abtc_pkg::ResetBracket;
      bracket_under <= abtc_pkg::ResetBracket;
      frames_left   <= '0;
      pending       <= 1'b0;
      held_over     <= '0;
      held_under    <= '0;
    end else if (in_valid && advance) begin
      threshold     <= threshold_next;
      bracket_over  <= bracket_over_next;
      bracket_under <= bracket_under_next;
      frames_left   <= frames_left_next;
      pending       <= pending_next;
      held_over     <= held_over_next;
      held_under    <= held_under_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid) begin
      m_axis_tdata <= {5'b0, r_reject, r_reuse, threshold_next, r_under, r_over, r_eval};
    end
  end

endmodule

`default_nettype wire

// ===== sv/abtc_checker.sv =====
// Port checker for the auto bracket threshold controller, bound to its top level.
// Uses the result field positions from abtc_pkg.
`default_nettype none

module abtc_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [31:0] m_axis_tdata
);

  logic       o_eval, o_reuse, o_reject;
  logic [7:0] o_over, o_under, o_use;

  assign o_eval   = m_axis_tdata[abtc_pkg::OutEvalBit];
  assign o_reuse  = m_axis_tdata[abtc_pkg::OutReuseBit];
  assign o_reject = m_axis_tdata[abtc_pkg::OutRejectBit];
  assign o_over   = m_axis_tdata[abtc_pkg::OutOverLsb +: 8];
  assign o_under  = m_axis_tdata[abtc_pkg::OutUnderLsb +: 8];
  assign o_use    = m_axis_tdata[abtc_pkg::OutUseLsb +: 8];

  // A stalled result stays put.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // No result appears straight after reset.
  a_reset: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result shown after reset");

  // An evaluation frame brackets the threshold in force.
  a_bracket: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && o_eval |-> o_under <= o_use && o_use <= o_over)
    else $error("trial thresholds do not bracket the threshold");

  // A rejected report carries no trials and no decision.
  a_reject: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && o_reject |-> !o_eval && !o_reuse && o_over == 8'd0 && o_under == 8'd0)
    else $error("rejected report carries trial data");

  // Centre reuse only answers a report, never a frame start.
  a_reuse: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && o_reuse |-> !o_eval && o_under <= o_use && o_use <= o_over)
    else $error("centre reuse outside a report");

endmodule

bind auto_bracket_threshold_controller_unit abtc_checker u_abtc_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
